// ===== rtl/core/imh_pkg.sv =====
// imh_pkg: types, constants and codes of the indexed min-heap unit
// no dependencies; imported by imh_datapath, imh_ctrl and indexed_min_heap_unit
package imh_pkg;

   localparam int CAPACITY = 64;
   localparam int ID_COUNT = 256;
   localparam int KEY_BITS = 32;

   localparam int ID_W    = $clog2(ID_COUNT);
   localparam int POS_W   = $clog2(CAPACITY);
   localparam int CNT_W   = $clog2(CAPACITY + 1);
   localparam int CHILD_W = POS_W + 1;
   localparam int OP_W    = 2;
   localparam int STAT_W  = 3;

   typedef logic [ID_W-1:0]     id_type;
   typedef logic [KEY_BITS-1:0] key_type;
   typedef logic [POS_W-1:0]    pos_type;
   typedef logic [CNT_W-1:0]    cnt_type;
   typedef logic [CHILD_W-1:0]  child_type;

   typedef struct packed {
      id_type  id;
      key_type key;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

   typedef enum logic [OP_W-1:0] {
      OP_INSERT   = 2'd0,
      OP_DECREASE = 2'd1,
      OP_EXTRACT  = 2'd2,
      OP_NONE     = 2'd3
   } op_type;

   typedef enum logic [STAT_W-1:0] {
      ST_OK          = 3'd0,
      ST_EMPTY       = 3'd1,
      ST_FULL        = 3'd2,
      ST_ABSENT      = 3'd3,
      ST_PRESENT     = 3'd4,
      ST_NOT_SMALLER = 3'd5
   } status_type;

   typedef enum logic [3:0] {
      DP_NOP,
      DP_LOAD,
      DP_ERR,
      DP_INS_BEGIN,
      DP_SLOT_RD,
      DP_DK_RD,
      DP_DK_SET,
      DP_UP_RD,
      DP_UP_MOVE,
      DP_PLACE,
      DP_EX_TOP,
      DP_EX_LAST,
      DP_DN_RDL,
      DP_DN_LEFT,
      DP_DN_RIGHT,
      DP_DN_MOVE
   } dp_op_type;

   typedef enum logic [4:0] {
      S_IDLE,
      S_DECODE,
      S_DK_WAIT,
      S_DK_CMP,
      S_UP_RD,
      S_UP_CMP,
      S_EX_TOP,
      S_EX_LAST,
      S_DN_RDL,
      S_DN_LEFT,
      S_DN_RIGHT,
      S_DN_CMP,
      S_ROOT,
      S_LATCH,
      S_RESP
   } state_type;

   typedef struct packed {
      dp_op_type  op;
      status_type err;
      logic       root_rd;
      logic       result;
   } cmd_type;

   typedef struct packed {
      op_type op;
      logic   present;
      logic   full;
      logic   empty;
      logic   occ_one;
      logic   key_lt;
      logic   parent_gt;
      logic   cand_lt;
      logic   pos_zero;
      logic   child_in;
      logic   right_in;
   } stat_type;

endpackage

// ===== rtl/core/imh_ram.sv =====
// imh_ram: generic single-write, single-read ram with registered read data
// no dependencies
module imh_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/core/imh_datapath.sv =====
// imh_datapath: heap slot ram, id-to-slot ram, present bits and working registers
// depends on imh_pkg and imh_ram; driven by commands from imh_ctrl
module imh_datapath (
   input  logic                clock,
   input  logic                reset,
   input  imh_pkg::cmd_type    cmd,
   output imh_pkg::stat_type   stat,
   input  logic [1:0]          req_operation,
   input  imh_pkg::id_type     req_item_id,
   input  imh_pkg::key_type    req_key,
   output logic [2:0]          rsp_status,
   output imh_pkg::id_type     rsp_removed_id,
   output imh_pkg::key_type    rsp_removed_key,
   output imh_pkg::cnt_type    rsp_entry_count,
   output imh_pkg::id_type     rsp_min_id,
   output imh_pkg::key_type    rsp_min_key,
   output logic                rsp_is_empty
);
   import imh_pkg::*;

   op_type     op_ff, op_in;
   id_type     id_ff, id_in;
   key_type    key_ff, key_in;
   entry_type  moving_ff, moving_in;
   entry_type  cand_ff, cand_in;
   pos_type    cand_pos_ff, cand_pos_in;
   pos_type    pos_ff, pos_in;
   cnt_type    occ_ff, occ_in;
   logic [ID_COUNT-1:0] present_ff, present_in;
   status_type status_ff, status_in;
   entry_type  removed_ff, removed_in;
   entry_type  min_ff, min_in;
   cnt_type    count_ff, count_in;
   logic       empty_ff, empty_in;

   entry_type  heap_rd, heap_wr_data;
   logic       heap_wr_en;
   pos_type    heap_wr_addr, heap_rd_addr;
   pos_type    slot_rd;
   logic       slot_wr_en;
   id_type     slot_wr_addr, slot_rd_addr;
   pos_type    slot_wr_data;

   child_type  child_w, right_w;
   pos_type    parent_w;

   assign child_w  = {pos_ff, 1'b1};
   assign right_w  = child_w + 1'b1;
   assign parent_w = pos_type'((pos_ff - 1'b1) >> 1);

   imh_ram #(.WIDTH(ENTRY_W), .DEPTH(CAPACITY)) u_heap_ram (
      .clock   (clock),
      .wr_en   (heap_wr_en),
      .wr_addr (heap_wr_addr),
      .wr_data (heap_wr_data),
      .rd_addr (heap_rd_addr),
      .rd_data (heap_rd)
   );

   imh_ram #(.WIDTH(POS_W), .DEPTH(ID_COUNT)) u_slot_ram (
      .clock   (clock),
      .wr_en   (slot_wr_en),
      .wr_addr (slot_wr_addr),
      .wr_data (slot_wr_data),
      .rd_addr (slot_rd_addr),
      .rd_data (slot_rd)
   );

   always_comb begin
      op_in       = op_ff;
      id_in       = id_ff;
      key_in      = key_ff;
      moving_in   = moving_ff;
      cand_in     = cand_ff;
      cand_pos_in = cand_pos_ff;
      pos_in      = pos_ff;
      occ_in      = occ_ff;
      present_in  = present_ff;
      status_in   = status_ff;
      removed_in  = removed_ff;
      min_in      = min_ff;
      count_in    = count_ff;
      empty_in    = empty_ff;
      heap_wr_en   = 1'b0;
      heap_wr_addr = pos_ff;
      heap_wr_data = moving_ff;
      heap_rd_addr = '0;
      slot_wr_en   = 1'b0;
      slot_wr_addr = moving_ff.id;
      slot_wr_data = pos_ff;
      slot_rd_addr = id_ff;
      case (cmd.op)
         DP_LOAD: begin
            op_in      = op_type'(req_operation);
            id_in      = req_item_id;
            key_in     = req_key;
            status_in  = ST_OK;
            removed_in = '0;
         end
         DP_ERR: begin
            status_in = cmd.err;
         end
         DP_INS_BEGIN: begin
            moving_in         = '{id: id_ff, key: key_ff};
            pos_in            = pos_type'(occ_ff);
            present_in[id_ff] = 1'b1;
            occ_in            = occ_ff + 1'b1;
         end
         DP_SLOT_RD: begin
            slot_rd_addr = id_ff;
         end
         DP_DK_RD: begin
            pos_in       = slot_rd;
            heap_rd_addr = slot_rd;
         end
         DP_DK_SET: begin
            moving_in = '{id: id_ff, key: key_ff};
         end
         DP_UP_RD: begin
            heap_rd_addr = parent_w;
         end
         DP_UP_MOVE: begin
            heap_wr_en   = 1'b1;
            heap_wr_data = heap_rd;
            slot_wr_en   = 1'b1;
            slot_wr_addr = heap_rd.id;
            pos_in       = parent_w;
         end
         DP_PLACE: begin
            heap_wr_en = 1'b1;
            slot_wr_en = 1'b1;
         end
         DP_EX_TOP: begin
            removed_in              = heap_rd;
            present_in[heap_rd.id]  = 1'b0;
            occ_in                  = occ_ff - 1'b1;
            heap_rd_addr            = pos_type'(occ_ff - 1'b1);
         end
         DP_EX_LAST: begin
            moving_in = heap_rd;
            pos_in    = '0;
         end
         DP_DN_RDL: begin
            heap_rd_addr = pos_type'(child_w);
         end
         DP_DN_LEFT: begin
            cand_in      = heap_rd;
            cand_pos_in  = pos_type'(child_w);
            heap_rd_addr = pos_type'(right_w);
         end
         DP_DN_RIGHT: begin
            if (heap_rd.key < cand_ff.key) begin
               cand_in     = heap_rd;
               cand_pos_in = pos_type'(right_w);
            end
         end
         DP_DN_MOVE: begin
            heap_wr_en   = 1'b1;
            heap_wr_data = cand_ff;
            slot_wr_en   = 1'b1;
            slot_wr_addr = cand_ff.id;
            pos_in       = cand_pos_ff;
         end
         default: begin
         end
      endcase
      if (cmd.root_rd) begin
         heap_rd_addr = '0;
      end
      if (cmd.result) begin
         count_in = occ_ff;
         empty_in = (occ_ff == '0);
         min_in   = (occ_ff == '0) ? '0 : heap_rd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         occ_ff     <= '0;
         present_ff <= '0;
      end else begin
         occ_ff     <= occ_in;
         present_ff <= present_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      id_ff       <= id_in;
      key_ff      <= key_in;
      moving_ff   <= moving_in;
      cand_ff     <= cand_in;
      cand_pos_ff <= cand_pos_in;
      pos_ff      <= pos_in;
      status_ff   <= status_in;
      removed_ff  <= removed_in;
      min_ff      <= min_in;
      count_ff    <= count_in;
      empty_ff    <= empty_in;
   end

   always_comb begin
      stat.op        = op_ff;
      stat.present   = present_ff[id_ff];
      stat.full      = (occ_ff == cnt_type'(CAPACITY));
      stat.empty     = (occ_ff == '0);
      stat.occ_one   = (occ_ff == cnt_type'(1));
      stat.key_lt    = (key_ff < heap_rd.key);
      stat.parent_gt = (heap_rd.key > moving_ff.key);
      stat.cand_lt   = (cand_ff.key < moving_ff.key);
      stat.pos_zero  = (pos_ff == '0);
      stat.child_in  = (child_w < child_type'(occ_ff));
      stat.right_in  = (right_w < child_type'(occ_ff));
   end

   assign rsp_status      = status_ff;
   assign rsp_removed_id  = removed_ff.id;
   assign rsp_removed_key = removed_ff.key;
   assign rsp_entry_count = count_ff;
   assign rsp_min_id      = min_ff.id;
   assign rsp_min_key     = min_ff.key;
   assign rsp_is_empty    = empty_ff;

   a_occ_matches_present: assert property (@(posedge clock) disable iff (reset)
      $countones(present_ff) == occ_ff)
      else $error("present bits disagree with occupancy");

   a_occ_bound: assert property (@(posedge clock) disable iff (reset)
      occ_ff <= cnt_type'(CAPACITY))
      else $error("occupancy above capacity");

   a_insert_grows: assert property (@(posedge clock) disable iff (reset)
      cmd.op == DP_INS_BEGIN |=> occ_ff == $past(occ_ff) + 1'b1)
      else $error("insert did not grow the heap");

   a_extract_clears: assert property (@(posedge clock) disable iff (reset)
      cmd.op == DP_EX_TOP |=> !present_ff[removed_ff.id])
      else $error("extracted id still present");

endmodule

// ===== rtl/core/imh_ctrl.sv =====
// imh_ctrl: sequencer for insert, decrease key and extract minimum
// depends on imh_pkg; issues commands to imh_datapath and reads its status
module imh_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   input  imh_pkg::stat_type  stat,
   output imh_pkg::cmd_type   cmd
);
   import imh_pkg::*;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in    = state_ff;
      cmd.op      = DP_NOP;
      cmd.err     = ST_OK;
      cmd.root_rd = 1'b0;
      cmd.result  = 1'b0;
      req_ready   = 1'b0;
      rsp_valid   = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.op   = DP_LOAD;
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            case (stat.op)
               OP_INSERT: begin
                  if (stat.present) begin
                     cmd.op   = DP_ERR;
                     cmd.err  = ST_PRESENT;
                     state_in = S_ROOT;
                  end else if (stat.full) begin
                     cmd.op   = DP_ERR;
                     cmd.err  = ST_FULL;
                     state_in = S_ROOT;
                  end else begin
                     cmd.op   = DP_INS_BEGIN;
                     state_in = S_UP_RD;
                  end
               end
               OP_DECREASE: begin
                  if (!stat.present) begin
                     cmd.op   = DP_ERR;
                     cmd.err  = ST_ABSENT;
                     state_in = S_ROOT;
                  end else begin
                     cmd.op   = DP_SLOT_RD;
                     state_in = S_DK_WAIT;
                  end
               end
               OP_EXTRACT: begin
                  if (stat.empty) begin
                     cmd.op   = DP_ERR;
                     cmd.err  = ST_EMPTY;
                     state_in = S_ROOT;
                  end else begin
                     cmd.root_rd = 1'b1;
                     state_in    = S_EX_TOP;
                  end
               end
               default: begin
                  state_in = S_ROOT;
               end
            endcase
         end
         S_DK_WAIT: begin
            cmd.op   = DP_DK_RD;
            state_in = S_DK_CMP;
         end
         S_DK_CMP: begin
            if (stat.key_lt) begin
               cmd.op   = DP_DK_SET;
               state_in = S_UP_RD;
            end else begin
               cmd.op   = DP_ERR;
               cmd.err  = ST_NOT_SMALLER;
               state_in = S_ROOT;
            end
         end
         S_UP_RD: begin
            if (stat.pos_zero) begin
               cmd.op   = DP_PLACE;
               state_in = S_ROOT;
            end else begin
               cmd.op   = DP_UP_RD;
               state_in = S_UP_CMP;
            end
         end
         S_UP_CMP: begin
            if (stat.parent_gt) begin
               cmd.op   = DP_UP_MOVE;
               state_in = S_UP_RD;
            end else begin
               cmd.op   = DP_PLACE;
               state_in = S_ROOT;
            end
         end
         S_EX_TOP: begin
            cmd.op   = DP_EX_TOP;
            state_in = stat.occ_one ? S_ROOT : S_EX_LAST;
         end
         S_EX_LAST: begin
            cmd.op   = DP_EX_LAST;
            state_in = S_DN_RDL;
         end
         S_DN_RDL: begin
            if (stat.child_in) begin
               cmd.op   = DP_DN_RDL;
               state_in = S_DN_LEFT;
            end else begin
               cmd.op   = DP_PLACE;
               state_in = S_ROOT;
            end
         end
         S_DN_LEFT: begin
            cmd.op   = DP_DN_LEFT;
            state_in = stat.right_in ? S_DN_RIGHT : S_DN_CMP;
         end
         S_DN_RIGHT: begin
            cmd.op   = DP_DN_RIGHT;
            state_in = S_DN_CMP;
         end
         S_DN_CMP: begin
            if (stat.cand_lt) begin
               cmd.op   = DP_DN_MOVE;
               state_in = S_DN_RDL;
            end else begin
               cmd.op   = DP_PLACE;
               state_in = S_ROOT;
            end
         end
         S_ROOT: begin
            cmd.root_rd = 1'b1;
            state_in    = S_LATCH;
         end
         S_LATCH: begin
            cmd.result = 1'b1;
            state_in   = S_RESP;
         end
         S_RESP: begin
            rsp_valid = 1'b1;
            if (rsp_ready) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   a_one_side: assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid))
      else $error("request taken while a response is pending");

   a_resp_after_latch: assert property (@(posedge clock) disable iff (reset)
      cmd.result |=> rsp_valid)
      else $error("latched result not presented");

   a_load_decodes: assert property (@(posedge clock) disable iff (reset)
      cmd.op == DP_LOAD |=> state_ff == S_DECODE)
      else $error("accepted request not decoded");

endmodule

// ===== rtl/core/indexed_min_heap_unit.sv =====
// indexed_min_heap_unit: indexed binary min-heap with decrease key
// depends on imh_pkg, imh_ctrl, imh_datapath and imh_ram
// one request at a time; insert and decrease key sift up, extract sifts the last entry down
// (no walk when the extracted entry was the only one), at most log2 of capacity levels per walk;
// walks wait on the registered heap ram read; the next request is taken in the cycle after the
// response is accepted; sync reset clears count and present bits, no sweep
module indexed_min_heap_unit (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [1:0]          req_operation,
   input  imh_pkg::id_type     req_item_id,
   input  imh_pkg::key_type    req_key,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [2:0]          rsp_status,
   output imh_pkg::id_type     rsp_removed_id,
   output imh_pkg::key_type    rsp_removed_key,
   output imh_pkg::cnt_type    rsp_entry_count,
   output imh_pkg::id_type     rsp_min_id,
   output imh_pkg::key_type    rsp_min_key,
   output logic                rsp_is_empty
);
   import imh_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   imh_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   imh_datapath u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .stat            (stat),
      .req_operation   (req_operation),
      .req_item_id     (req_item_id),
      .req_key         (req_key),
      .rsp_status      (rsp_status),
      .rsp_removed_id  (rsp_removed_id),
      .rsp_removed_key (rsp_removed_key),
      .rsp_entry_count (rsp_entry_count),
      .rsp_min_id      (rsp_min_id),
      .rsp_min_key     (rsp_min_key),
      .rsp_is_empty    (rsp_is_empty)
   );

endmodule

// ===== test/tb_indexed_min_heap_unit.sv =====
// tb_indexed_min_heap_unit: self-checking testbench of the indexed min-heap unit
// a scoreboard class predicts every response from its own heap copy; tasks drive requests
// depends on imh_pkg and indexed_min_heap_unit
`timescale 1ns / 100ps

typedef struct {
   imh_pkg::status_type status;
   imh_pkg::id_type     removed_id;
   imh_pkg::key_type    removed_key;
   imh_pkg::cnt_type    entry_count;
   imh_pkg::id_type     min_id;
   imh_pkg::key_type    min_key;
   logic                is_empty;
} response_type;

class heap_scoreboard;
   imh_pkg::id_type  slot_id[imh_pkg::CAPACITY];
   imh_pkg::key_type slot_key[imh_pkg::CAPACITY];
   int               slot_of[imh_pkg::ID_COUNT];
   bit               present[imh_pkg::ID_COUNT];
   int               occupancy;
   response_type     expected_responses[$];
   int               mismatches;
   int               checked;

   function new();
      occupancy = 0;
      mismatches = 0;
      checked = 0;
      foreach (present[i]) begin
         present[i] = 0;
         slot_of[i] = 0;
      end
   endfunction

   function void place(int pos, imh_pkg::id_type id, imh_pkg::key_type key);
      slot_id[pos] = id;
      slot_key[pos] = key;
      slot_of[id] = pos;
   endfunction

   function void bubble_up(int pos);
      imh_pkg::id_type  mid;
      imh_pkg::key_type mkey;
      int               parent;
      mid = slot_id[pos];
      mkey = slot_key[pos];
      while (pos > 0) begin
         parent = (pos - 1) / 2;
         if (!(slot_key[parent] > mkey)) break;
         place(pos, slot_id[parent], slot_key[parent]);
         pos = parent;
      end
      place(pos, mid, mkey);
   endfunction

   function void bubble_down(int pos);
      imh_pkg::id_type  mid;
      imh_pkg::key_type mkey;
      int               child;
      mid = slot_id[pos];
      mkey = slot_key[pos];
      while (pos * 2 + 1 < occupancy) begin
         child = pos * 2 + 1;
         if (child + 1 < occupancy && slot_key[child + 1] < slot_key[child]) child++;
         if (!(slot_key[child] < mkey)) break;
         place(pos, slot_id[child], slot_key[child]);
         pos = child;
      end
      place(pos, mid, mkey);
   endfunction

   function void note_request(imh_pkg::op_type op, imh_pkg::id_type id,
                              imh_pkg::key_type key);
      response_type r;
      int           pos;
      r.status = imh_pkg::ST_OK;
      r.removed_id = '0;
      r.removed_key = '0;
      case (op)
         imh_pkg::OP_INSERT: begin
            if (present[id]) r.status = imh_pkg::ST_PRESENT;
            else if (occupancy >= imh_pkg::CAPACITY) r.status = imh_pkg::ST_FULL;
            else begin
               slot_id[occupancy] = id;
               slot_key[occupancy] = key;
               present[id] = 1;
               occupancy++;
               bubble_up(occupancy - 1);
            end
         end
         imh_pkg::OP_DECREASE: begin
            if (!present[id] || slot_of[id] >= occupancy) r.status = imh_pkg::ST_ABSENT;
            else begin
               pos = slot_of[id];
               if (!(key < slot_key[pos])) r.status = imh_pkg::ST_NOT_SMALLER;
               else begin
                  slot_key[pos] = key;
                  bubble_up(pos);
               end
            end
         end
         imh_pkg::OP_EXTRACT: begin
            if (occupancy == 0) r.status = imh_pkg::ST_EMPTY;
            else begin
               r.removed_id = slot_id[0];
               r.removed_key = slot_key[0];
               present[slot_id[0]] = 0;
               slot_of[slot_id[0]] = 0;
               occupancy--;
               if (occupancy > 0) begin
                  slot_id[0] = slot_id[occupancy];
                  slot_key[0] = slot_key[occupancy];
                  bubble_down(0);
               end
            end
         end
         default: ;
      endcase
      r.entry_count = occupancy;
      r.min_id = (occupancy > 0) ? slot_id[0] : '0;
      r.min_key = (occupancy > 0) ? slot_key[0] : '0;
      r.is_empty = (occupancy == 0);
      expected_responses.push_back(r);
   endfunction

   task report(string field, longint got, longint want);
      $display("mismatch on response %0d: %s got %0h expected %0h", checked, field, got, want);
      mismatches++;
   endtask

   task check_response(response_type got);
      response_type want;
      if (expected_responses.size() == 0) begin
         $display("response %0d arrived with no request outstanding", checked);
         mismatches++;
      end else begin
         want = expected_responses.pop_front();
         if (got.status !== want.status) report("status", got.status, want.status);
         if (got.removed_id !== want.removed_id)
            report("removed_id", got.removed_id, want.removed_id);
         if (got.removed_key !== want.removed_key)
            report("removed_key", got.removed_key, want.removed_key);
         if (got.entry_count !== want.entry_count)
            report("entry_count", got.entry_count, want.entry_count);
         if (got.min_id !== want.min_id) report("min_id", got.min_id, want.min_id);
         if (got.min_key !== want.min_key) report("min_key", got.min_key, want.min_key);
         if (got.is_empty !== want.is_empty) report("is_empty", got.is_empty, want.is_empty);
      end
      checked++;
   endtask
endclass

module tb_indexed_min_heap_unit;
   import imh_pkg::*;

   logic             clock;
   logic             reset;
   logic             req_valid;
   logic             req_ready;
   logic [1:0]       req_operation;
   id_type           req_item_id;
   key_type          req_key;
   logic             rsp_valid;
   logic             rsp_ready;
   logic [2:0]       rsp_status;
   id_type           rsp_removed_id;
   key_type          rsp_removed_key;
   cnt_type          rsp_entry_count;
   id_type           rsp_min_id;
   key_type          rsp_min_key;
   logic             rsp_is_empty;

   heap_scoreboard   sb;
   bit               calm_stretch;
   bit               hold_request;
   int               sent;

   indexed_min_heap_unit dut (.*);

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   initial begin
      #5ms;
      $display("timeout");
      $display("indexed_min_heap_unit verification failed");
      $finish;
   end

   function automatic key_type pick_key();
      return ($urandom_range(1) == 0) ? key_type'($urandom) : key_type'($urandom_range(20));
   endfunction

   task automatic send_request(op_type op, id_type id, key_type key);
      int gap;
      if (!calm_stretch && $urandom_range(99) < 38) begin
         gap = $urandom_range(6, 1);
         req_valid <= 0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1;
      req_operation <= op;
      req_item_id <= id;
      req_key <= key;
      do @(posedge clock); while (!req_ready);
      sb.note_request(op, id, key);
      sent++;
   endtask

   task automatic send_random(int mode);
      int      roll;
      id_type  id;
      key_type key;
      int      pos;
      roll = $urandom_range(99);
      if (roll < 8) begin
         send_request(op_type'($urandom_range(3)), id_type'($urandom), key_type'($urandom));
      end else if ((mode == 0 && roll < 80) || (mode == 2 && roll < 45)
                   || (mode == 1 && roll < 20)) begin
         id = id_type'($urandom);
         repeat (4) if (sb.present[id]) id = id_type'($urandom);
         send_request(OP_INSERT, id, pick_key());
      end else if (sb.occupancy > 0 && ((mode == 1 && roll < 40) || (mode != 1 && roll < 88))) begin
         pos = $urandom_range(sb.occupancy - 1);
         id = sb.slot_id[pos];
         key = sb.slot_key[pos];
         if (key != 0 && $urandom_range(9) != 0) key = key - $urandom_range(key, 1);
         else key = pick_key();
         send_request(OP_DECREASE, id, key);
      end else begin
         send_request(OP_EXTRACT, id_type'($urandom), key_type'($urandom));
      end
   endtask

   initial begin
      response_type_decl: begin
         response_type got;
         rsp_ready = 0;
         forever begin
            @(posedge clock);
            if (!reset && rsp_valid && rsp_ready) begin
               got.status = status_type'(rsp_status);
               got.removed_id = rsp_removed_id;
               got.removed_key = rsp_removed_key;
               got.entry_count = rsp_entry_count;
               got.min_id = rsp_min_id;
               got.min_key = rsp_min_key;
               got.is_empty = rsp_is_empty;
               sb.check_response(got);
            end
            if (hold_request) begin
               rsp_ready <= 0;
               repeat (300) @(posedge clock);
               hold_request = 0;
            end else begin
               rsp_ready <= calm_stretch || ($urandom_range(99) >= 38);
            end
         end
      end
   end

   initial begin
      int mode;
      int wait_cycles;
      sb = new();
      calm_stretch = 0;
      hold_request = 0;
      sent = 0;
      reset = 1;
      req_valid = 0;
      req_operation = OP_NONE;
      req_item_id = '0;
      req_key = '0;
      repeat (9) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed corners
      send_request(OP_EXTRACT, 8'd3, 32'd0);
      send_request(OP_NONE, 8'hff, 32'hffff_ffff);
      send_request(OP_INSERT, 8'd5, 32'd100);
      send_request(OP_INSERT, 8'd5, 32'd7);
      send_request(OP_INSERT, 8'd0, 32'd0);
      send_request(OP_INSERT, 8'hff, 32'hffff_ffff);
      send_request(OP_DECREASE, 8'd9, 32'd1);
      send_request(OP_DECREASE, 8'hff, 32'hffff_ffff);
      send_request(OP_DECREASE, 8'hff, 32'd3);
      send_request(OP_DECREASE, 8'd5, 32'd100);
      send_request(OP_DECREASE, 8'd5, 32'd0);
      send_request(OP_INSERT, 8'd128, 32'h8000_0000);
      send_request(OP_INSERT, 8'd77, 32'd3);
      send_request(OP_NONE, 8'd0, 32'd0);
      repeat (6) send_request(OP_EXTRACT, 8'd0, 32'd0);

      mode = 0;
      for (int i = 0; i < 1130; i++) begin
         if (i >= 90 && i % 60 == 0) mode = $urandom_range(2);
         calm_stretch = (i >= 300 && i < 450);
         if (i == 600) hold_request = 1;
         if (i == 850) begin
            req_valid <= 0;
            while (sb.expected_responses.size() != 0) @(posedge clock);
         end
         send_random(mode);
      end
      req_valid <= 0;

      while (sb.expected_responses.size() != 0) @(posedge clock);
      wait_cycles = 0;
      while (wait_cycles < 60) begin
         @(posedge clock);
         wait_cycles++;
      end
      if (sb.expected_responses.size() != 0) begin
         $display("%0d responses never arrived", sb.expected_responses.size());
         sb.mismatches++;
      end
      $display("sent %0d requests, checked %0d responses across fill, drain and mixed phases",
               sent, sb.checked);
      if (sb.mismatches == 0) begin
         $display("indexed_min_heap_unit verification clean");
      end else begin
         $display("indexed_min_heap_unit verification failed");
      end
      $finish;
   end

endmodule
